FILE: hdl/meter_poll_timeout_retry_core_macros.svh
// Assertion macros for the meter poll core.
`ifndef METER_POLL_TIMEOUT_RETRY_CORE_MACROS_SVH
`define METER_POLL_TIMEOUT_RETRY_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define MPTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mptr assertion failed");
`define MPTR_ASSERT_NEXT(lbl, pre, post) \
  `MPTR_ASSERT(lbl, (pre) |=> (post))
`else
`define MPTR_ASSERT(lbl, prop)
`define MPTR_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: hdl/mptr_pkg.sv
package mptr_pkg;

  localparam int unsigned TickW    = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned VoltW    = 16;
  localparam int unsigned ChanW    = 32;
  localparam int unsigned SumW     = 33;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DelayW-1:0] AskDelayReset     = 16'd1000;
  localparam logic [DelayW-1:0] ReplyTimeoutReset = 16'd500;
  localparam logic [LimitW-1:0] RetryLimitReset   = 8'd3;
  localparam logic              ErrorSet          = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ASK_DELAY     = 2'd0,
    CFG_REPLY_TIMEOUT = 2'd1,
    CFG_RETRY_LIMIT   = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_NACK = 2'd2,
    ST_BAD  = 2'd3
  } parse_status_e;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_BASICS = 2'd1,
    REQ_POWERS = 2'd2,
    REQ_RSVD   = 2'd3
  } request_e;

  typedef enum logic {
    KIND_BASICS = 1'b0,
    KIND_POWERS = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic [DelayW-1:0] req_gap_ms;
    logic [DelayW-1:0] reply_timeout_ms;
    logic [LimitW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [TickW-1:0] now_ms;
    logic             frame_received;
    parse_status_e    parse_status;
    logic [VoltW-1:0] voltage_in;
    logic [ChanW-1:0] active_power_ch1;
    logic [ChanW-1:0] active_power_ch2;
    logic [ChanW-1:0] current_ch1;
    logic [ChanW-1:0] current_ch2;
  } poll_item_t;

  typedef struct packed {
    request_e         request_sent;
    logic [VoltW-1:0] voltage_out;
    logic [SumW-1:0]  power_total;
    logic [SumW-1:0]  current_total;
    logic             link_error;
  } poll_res_t;

endpackage

FILE: hdl/mptr_poll.sv
module mptr_poll import mptr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  poll_item_t item_i,
  input  logic       take_i,
  output poll_res_t  res_o,
  output logic       awaiting_o
);

  req_kind_e         kind_q, kind_d;
  logic [TickW-1:0]  last_q, last_d;
  logic [TickW-1:0]  start_q, start_d;
  logic              await_q, await_d;
  logic [LimitW-1:0] tcount_q, tcount_d;
  logic [LimitW-1:0] ncount_q, ncount_d;
  logic [VoltW-1:0]  volt_q, volt_d;
  logic [SumW-1:0]   power_q, power_d;
  logic [SumW-1:0]   curr_q, curr_d;
  logic              err_q, err_d;

  logic [TickW-1:0]  since_req;
  logic [TickW-1:0]  since_start;
  logic              issue;
  request_e          sent;

  always_comb begin
    since_req   = item_i.now_ms - last_q;
    issue       = (since_req > {{(TickW-DelayW){1'b0}}, cfg_i.req_gap_ms}) && !await_q;
    kind_d      = kind_q;
    last_d      = last_q;
    start_d     = start_q;
    await_d     = await_q;
    tcount_d    = tcount_q;
    ncount_d    = ncount_q;
    volt_d      = volt_q;
    power_d     = power_q;
    curr_d      = curr_q;
    err_d       = err_q;
    sent        = REQ_NONE;

    if (issue) begin
      sent    = (kind_q == KIND_BASICS) ? REQ_BASICS : REQ_POWERS;
      kind_d  = (kind_q == KIND_BASICS) ? KIND_POWERS : KIND_BASICS;
      await_d = 1'b1;
      last_d  = item_i.now_ms;
      start_d = item_i.now_ms;
    end

    since_start = item_i.now_ms - start_d;

    if (item_i.frame_received) begin
      unique case (item_i.parse_status)
        ST_OK: begin
          volt_d  = item_i.voltage_in;
          power_d = {1'b0, item_i.active_power_ch1} + {1'b0, item_i.active_power_ch2};
          curr_d  = {1'b0, item_i.current_ch1} + {1'b0, item_i.current_ch2};
          err_d   = 1'b0;
        end
        ST_BUSY: begin
        end
        ST_NACK, ST_BAD: begin
          ncount_d = ncount_q + 8'd1;
          if (ncount_d >= cfg_i.retry_limit) begin
            err_d    = ErrorSet;
            ncount_d = '0;
          end
        end
        default: begin
        end
      endcase
      await_d  = 1'b0;
      tcount_d = '0;
    end else if (since_start > {{(TickW-DelayW){1'b0}}, cfg_i.reply_timeout_ms}) begin
      last_d   = item_i.now_ms;
      start_d  = item_i.now_ms;
      await_d  = 1'b0;
      tcount_d = tcount_q + 8'd1;
      if (tcount_d >= cfg_i.retry_limit) begin
        err_d    = ErrorSet;
        volt_d   = '0;
        power_d  = '0;
        curr_d   = '0;
        tcount_d = '0;
      end
    end

    res_o.request_sent  = sent;
    res_o.voltage_out   = volt_d;
    res_o.power_total   = power_d;
    res_o.current_total = curr_d;
    res_o.link_error    = err_d;
  end

  assign awaiting_o = await_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_BASICS;
      last_q   <= '0;
      start_q  <= '0;
      await_q  <= 1'b0;
      tcount_q <= '0;
      ncount_q <= '0;
      volt_q   <= '0;
      power_q  <= '0;
      curr_q   <= '0;
      err_q    <= 1'b0;
    end else if (take_i) begin
      kind_q   <= kind_d;
      last_q   <= last_d;
      start_q  <= start_d;
      await_q  <= await_d;
      tcount_q <= tcount_d;
      ncount_q <= ncount_d;
      volt_q   <= volt_d;
      power_q  <= power_d;
      curr_q   <= curr_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: hdl/meter_poll_timeout_retry_core.sv
// Energy-meter poll controller. Each input transaction is one poll call
// carrying the millisecond tick and, if a reply frame came in, its parse
// status and values; each yields exactly one result transaction with the
// request issued (none, basics or powers) and the published voltage, power
// sum, current sum and link error. An item passes an input register and
// the poll logic into the output register; a new item is taken every cycle
// while the output is not stalled. The state update is a 32-bit tick
// subtract-and-compare plus 33-bit sums. Write the three
// configuration registers only while no transaction is in flight.
`include "meter_poll_timeout_retry_core_macros.svh"

module meter_poll_timeout_retry_core import mptr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TickW-1:0]    now_ms_i,
  input  logic                frame_received_i,
  input  logic [1:0]          parse_status_i,
  input  logic [VoltW-1:0]    voltage_in_i,
  input  logic [ChanW-1:0]    active_power_ch1_i,
  input  logic [ChanW-1:0]    active_power_ch2_i,
  input  logic [ChanW-1:0]    current_ch1_i,
  input  logic [ChanW-1:0]    current_ch2_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          request_sent_o,
  output logic [VoltW-1:0]    voltage_out_o,
  output logic [SumW-1:0]     power_total_o,
  output logic [SumW-1:0]     current_total_o,
  output logic                link_error_o
);

  cfg_t       cfg_q;
  poll_item_t item_q;
  logic       in_valid_q;
  poll_res_t  res_d, res_q;
  logic       out_valid_q;
  logic       in_accept;
  logic       out_load;
  logic       awaiting;

  // output stage free or draining this cycle
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.req_gap_ms       <= AskDelayReset;
      cfg_q.reply_timeout_ms <= ReplyTimeoutReset;
      cfg_q.retry_limit      <= RetryLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ASK_DELAY:     cfg_q.req_gap_ms       <= cfg_wdata_i;
        CFG_REPLY_TIMEOUT: cfg_q.reply_timeout_ms <= cfg_wdata_i;
        CFG_RETRY_LIMIT:   cfg_q.retry_limit      <= cfg_wdata_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.now_ms           <= now_ms_i;
      item_q.frame_received   <= frame_received_i;
      item_q.parse_status     <= parse_status_e'(parse_status_i);
      item_q.voltage_in       <= voltage_in_i;
      item_q.active_power_ch1 <= active_power_ch1_i;
      item_q.active_power_ch2 <= active_power_ch2_i;
      item_q.current_ch1      <= current_ch1_i;
      item_q.current_ch2      <= current_ch2_i;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  mptr_poll u_poll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item_q),
    .take_i     (out_load),
    .res_o      (res_d),
    .awaiting_o (awaiting)
  );

  assign out_valid_o     = out_valid_q;
  assign request_sent_o  = res_q.request_sent;
  assign voltage_out_o   = res_q.voltage_out;
  assign power_total_o   = res_q.power_total;
  assign current_total_o = res_q.current_total;
  assign link_error_o    = res_q.link_error;

  `MPTR_ASSERT(a_no_req_while_waiting, (out_load && awaiting) |-> (res_d.request_sent == REQ_NONE))
  `MPTR_ASSERT(a_req_code_legal, out_valid_q |-> (res_q.request_sent != REQ_RSVD))
  `MPTR_ASSERT(a_free_output_loads, (in_valid_q && !out_stall_i) |-> out_load)
  `MPTR_ASSERT_NEXT(a_load_shows, out_load, out_valid_q)

endmodule

FILE: sim/tb_meter_poll_timeout_retry_core.sv
module tb_meter_poll_timeout_retry_core;
  import mptr_pkg::*;

  localparam int unsigned IdleLimit = 5000;

  class poll_scoreboard;
    cfg_t              cfg;
    req_kind_e         next_kind;
    logic [TickW-1:0]  last_req_tick;
    logic [TickW-1:0]  timeout_mark;
    bit                awaiting;
    logic [LimitW-1:0] timeout_cnt;
    logic [LimitW-1:0] nack_cnt;
    logic [VoltW-1:0]  held_volt;
    logic [SumW-1:0]   held_power;
    logic [SumW-1:0]   held_current;
    logic              held_err;
    poll_res_t         poll_results_q[$];
    int                errors;

    function new();
      cfg           = '{AskDelayReset, ReplyTimeoutReset, RetryLimitReset};
      next_kind     = KIND_BASICS;
      last_req_tick = '0;
      timeout_mark  = '0;
      awaiting      = 1'b0;
      timeout_cnt   = '0;
      nack_cnt      = '0;
      held_volt     = '0;
      held_power    = '0;
      held_current  = '0;
      held_err      = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ASK_DELAY:     cfg.req_gap_ms       = data;
        CFG_REPLY_TIMEOUT: cfg.reply_timeout_ms = data;
        CFG_RETRY_LIMIT:   cfg.retry_limit      = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return poll_results_q.size();
    endfunction

    // one input transaction -> exactly one result transaction
    function void note_poll(poll_item_t it);
      poll_res_t        want;
      logic [TickW-1:0] since;
      want.request_sent = REQ_NONE;
      since = it.now_ms - last_req_tick;
      if (since > cfg.req_gap_ms && !awaiting) begin
        want.request_sent = (next_kind == KIND_BASICS) ? REQ_BASICS : REQ_POWERS;
        next_kind = (next_kind == KIND_BASICS) ? KIND_POWERS : KIND_BASICS;
        awaiting      = 1'b1;
        last_req_tick = it.now_ms;
        timeout_mark  = it.now_ms;
      end
      since = it.now_ms - timeout_mark;
      if (it.frame_received) begin
        case (it.parse_status)
          ST_OK: begin
            held_volt    = it.voltage_in;
            held_power   = {1'b0, it.active_power_ch1} + {1'b0, it.active_power_ch2};
            held_current = {1'b0, it.current_ch1} + {1'b0, it.current_ch2};
            held_err     = 1'b0;
          end
          ST_BUSY: ;
          default: begin
            nack_cnt = nack_cnt + 1'b1;
            if (nack_cnt >= cfg.retry_limit) begin
              held_err = ErrorSet;
              nack_cnt = '0;
            end
          end
        endcase
        awaiting    = 1'b0;
        timeout_cnt = '0;
      end else if (since > cfg.reply_timeout_ms) begin
        last_req_tick = it.now_ms;
        timeout_mark  = it.now_ms;
        awaiting      = 1'b0;
        timeout_cnt   = timeout_cnt + 1'b1;
        if (timeout_cnt >= cfg.retry_limit) begin
          held_err     = ErrorSet;
          held_volt    = '0;
          held_power   = '0;
          held_current = '0;
          timeout_cnt  = '0;
        end
      end
      want.voltage_out   = held_volt;
      want.power_total   = held_power;
      want.current_total = held_current;
      want.link_error    = held_err;
      poll_results_q.push_back(want);
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task check_result(poll_res_t got);
      poll_res_t want;
      if (poll_results_q.size() == 0) begin
        report("unexpected result transaction", '0, got.request_sent);
        return;
      end
      want = poll_results_q.pop_front();
      if (got.request_sent !== want.request_sent)
        report("request_sent", want.request_sent, got.request_sent);
      if (got.voltage_out !== want.voltage_out)
        report("voltage_out", want.voltage_out, got.voltage_out);
      if (got.power_total !== want.power_total)
        report("power_total", want.power_total, got.power_total);
      if (got.current_total !== want.current_total)
        report("current_total", want.current_total, got.current_total);
      if (got.link_error !== want.link_error)
        report("link_error", want.link_error, got.link_error);
    endtask
  endclass

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i          = '0;
  logic [CfgDataW-1:0] cfg_wdata_i        = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [TickW-1:0]    now_ms_i           = '0;
  logic                frame_received_i   = 1'b0;
  logic [1:0]          parse_status_i     = '0;
  logic [VoltW-1:0]    voltage_in_i       = '0;
  logic [ChanW-1:0]    active_power_ch1_i = '0;
  logic [ChanW-1:0]    active_power_ch2_i = '0;
  logic [ChanW-1:0]    current_ch1_i      = '0;
  logic [ChanW-1:0]    current_ch2_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [1:0]          request_sent_o;
  logic [VoltW-1:0]    voltage_out_o;
  logic [SumW-1:0]     power_total_o;
  logic [SumW-1:0]     current_total_o;
  logic                link_error_o;

  poll_scoreboard   sb = new();
  logic [TickW-1:0] tick = '0;
  bit               calm = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      idle_cycles = 0;

  meter_poll_timeout_retry_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .now_ms_i           (now_ms_i),
    .frame_received_i   (frame_received_i),
    .parse_status_i     (parse_status_i),
    .voltage_in_i       (voltage_in_i),
    .active_power_ch1_i (active_power_ch1_i),
    .active_power_ch2_i (active_power_ch2_i),
    .current_ch1_i      (current_ch1_i),
    .current_ch2_i      (current_ch2_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .request_sent_o     (request_sent_o),
    .voltage_out_o      (voltage_out_o),
    .power_total_o      (power_total_o),
    .current_total_o    (current_total_o),
    .link_error_o       (link_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ChanW-1:0] wide_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return '1;
    return $urandom();
  endfunction

  // steps cluster around the spacing and timeout thresholds
  function automatic logic [TickW-1:0] tick_step();
    int unsigned      r;
    logic [TickW-1:0] ask;
    logic [TickW-1:0] tmo;
    ask = sb.cfg.req_gap_ms;
    tmo = sb.cfg.reply_timeout_ms;
    r = $urandom_range(0, 19);
    if (r < 8) return $urandom_range(0, 3);
    if (r < 13) return ask + $urandom_range(0, 2) - 1;
    if (r < 18) return tmo + $urandom_range(0, 2) - 1;
    return $urandom();
  endfunction

  function automatic poll_item_t make_poll();
    poll_item_t  it;
    int unsigned r;
    tick = tick + tick_step();
    it.now_ms = tick;
    r = $urandom_range(0, 99);
    it.frame_received = sb.awaiting ? (r < 65) : (r < 15);
    r = $urandom_range(0, 99);
    if (r < 45) it.parse_status = ST_OK;
    else if (r < 60) it.parse_status = ST_BUSY;
    else if (r < 90) it.parse_status = ST_NACK;
    else it.parse_status = ST_BAD;
    it.voltage_in       = ($urandom_range(0, 9) == 0) ? '1 : 16'($urandom());
    it.active_power_ch1 = wide_value();
    it.active_power_ch2 = wide_value();
    it.current_ch1      = wide_value();
    it.current_ch2      = wide_value();
    if ($urandom_range(0, 9) == 0) begin
      it.now_ms         = $urandom();
      it.frame_received = 1'($urandom_range(0, 1));
      it.parse_status   = parse_status_e'($urandom_range(0, 3));
      tick              = it.now_ms;
    end
    return it;
  endfunction

  task automatic send_poll(poll_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    now_ms_i           <= it.now_ms;
    frame_received_i   <= it.frame_received;
    parse_status_i     <= it.parse_status;
    voltage_in_i       <= it.voltage_in;
    active_power_ch1_i <= it.active_power_ch1;
    active_power_ch2_i <= it.active_power_ch2;
    current_ch1_i      <= it.current_ch1;
    current_ch2_i      <= it.current_ch2;
    in_valid_i         <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_poll(it);
  endtask

  task automatic poll(logic [TickW-1:0] now, logic frame, parse_status_e st,
                      logic [VoltW-1:0] v, logic [ChanW-1:0] p1, logic [ChanW-1:0] p2,
                      logic [ChanW-1:0] c1, logic [ChanW-1:0] c2);
    poll_item_t it;
    it   = '{now, frame, st, v, p1, p2, c1, c2};
    tick = now;
    send_poll(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [DelayW-1:0] ask, logic [DelayW-1:0] tmo,
                            logic [LimitW-1:0] lim);
    write_reg(CFG_ASK_DELAY, ask);
    write_reg(CFG_REPLY_TIMEOUT, tmo);
    write_reg(CFG_RETRY_LIMIT, {8'($urandom_range(0, 255)), lim});
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    poll_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.request_sent  = request_e'(request_sent_o);
      got.voltage_out   = voltage_out_o;
      got.power_total   = power_total_o;
      got.current_total = current_total_o;
      got.link_error    = link_error_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pause_at;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // timeout below spacing so idle timeouts can occur
    set_config(16'd10, 16'd3, 8'd2);
    poll(32'd0,  1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd11, 1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd11, 1'b1, ST_OK,   '1,    '1, '1, '1, '1);
    poll(32'd22, 1'b1, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd33, 1'b1, ST_BUSY, 16'h5a5a, 32'h1234_5678, 32'h9abc_def0, 32'h1, 32'h2);
    poll(32'd44, 1'b1, ST_NACK, '1,    '1, '1, '1, '1);
    poll(32'd55, 1'b1, ST_BAD,  '1,    '1, '1, '1, '1);
    poll(32'd66, 1'b1, ST_OK,   16'd1234, 32'd1, 32'd2, 32'd3, 32'd4);
    poll(32'd77, 1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd81, 1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd85, 1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd85, 1'b1, ST_BUSY, '1,    '1, '1, '1, '1);
    poll(32'hffff_fff0, 1'b0, ST_OK, '0, '0, '0, '0, '0);
    poll(32'd2,  1'b0, ST_OK,   '0,    '0, '0, '0, '0);
    poll(32'd2,  1'b1, ST_NACK, '0,    '0, '0, '0, '0);
    poll(32'hffff_ffff, 1'b1, ST_OK, '1, 32'h8000_0000, 32'h8000_0000, '1, '0);
    drain_results();

    write_reg(CFG_UNUSED, 16'($urandom()));
    set_config('0, '0, '0);
    poll(32'd100, 1'b1, ST_NACK, '0, '0, '0, '0, '0);
    poll(32'd100, 1'b0, ST_OK,   '0, '0, '0, '0, '0);
    poll(32'd101, 1'b0, ST_OK,   '0, '0, '0, '0, '0);
    poll(32'd102, 1'b0, ST_OK,   '0, '0, '0, '0, '0);
    poll(32'd102, 1'b1, ST_OK,   16'd230, 32'd500, 32'd700, 32'd10, 32'd20);
    poll(32'd103, 1'b0, ST_BUSY, '0, '0, '0, '0, '0);

    for (int phase = 0; phase < 14; phase++) begin
      drain_results();
      calm = (phase % 4 == 3);
      case (phase)
        0: set_config(AskDelayReset, ReplyTimeoutReset, RetryLimitReset);
        1: set_config('0, '0, '0);
        2: set_config('1, '1, '1);
        3: set_config('0, '1, 8'd1);
        4: set_config('1, '0, 8'd2);
        default: set_config(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                            8'($urandom_range(0, 5)));
      endcase
      tick     = $urandom();
      pause_at = $urandom_range(10, 110);
      for (int k = 0; k < 125; k++) begin
        if (k == pause_at) drain_results();
        send_poll(make_poll());
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
